### hw/rtl/gsbu_pkg.sv
`timescale 1ns / 1ps

package gsbu_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CountW  = 4;

  // Parse phases
  localparam logic [PhaseW-1:0] PH_HDR     = 4'd0;
  localparam logic [PhaseW-1:0] PH_XLEN    = 4'd1;
  localparam logic [PhaseW-1:0] PH_XDATA   = 4'd2;
  localparam logic [PhaseW-1:0] PH_NAME    = 4'd3;
  localparam logic [PhaseW-1:0] PH_COMMENT = 4'd4;
  localparam logic [PhaseW-1:0] PH_HCRC    = 4'd5;
  localparam logic [PhaseW-1:0] PH_BLKHDR  = 4'd6;
  localparam logic [PhaseW-1:0] PH_LENS    = 4'd7;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd8;
  localparam logic [PhaseW-1:0] PH_TRAILER = 4'd9;
  localparam logic [PhaseW-1:0] PH_DONE    = 4'd10;

  // Status codes
  localparam logic [StatusW-1:0] ST_BUSY     = 3'd0;
  localparam logic [StatusW-1:0] ST_OK       = 3'd1;
  localparam logic [StatusW-1:0] ST_BADHDR   = 3'd2;
  localparam logic [StatusW-1:0] ST_BADTYPE  = 3'd3;
  localparam logic [StatusW-1:0] ST_BADLEN   = 3'd4;
  localparam logic [StatusW-1:0] ST_BADCHECK = 3'd5;
  localparam logic [StatusW-1:0] ST_TRUNC    = 3'd6;

  // Header constants
  localparam logic [ByteW-1:0] MAGIC0     = 8'h1f;
  localparam logic [ByteW-1:0] MAGIC1     = 8'h8b;
  localparam logic [ByteW-1:0] METHOD_DEF = 8'h08;
  localparam int unsigned      FlgHcrc    = 1;
  localparam int unsigned      FlgExtra   = 2;
  localparam int unsigned      FlgName    = 3;
  localparam int unsigned      FlgComment = 4;

  // Optional header sections, in stream order
  localparam logic [2:0] SEC_EXTRA   = 3'd0;
  localparam logic [2:0] SEC_NAME    = 3'd1;
  localparam logic [2:0] SEC_COMMENT = 3'd2;
  localparam logic [2:0] SEC_HCRC    = 3'd3;
  localparam logic [2:0] SEC_NONE    = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic               payload_valid;
    logic [StatusW-1:0] status;
  } gsbu_result_t;

  // First announced section at or after sec, else the first block header
  function automatic logic [PhaseW-1:0] next_section(input logic [2:0] sec,
                                                      input logic [7:0] flags);
    logic [PhaseW-1:0] ph;
    ph = PH_BLKHDR;
    if (sec <= SEC_HCRC && flags[FlgHcrc]) ph = PH_HCRC;
    if (sec <= SEC_COMMENT && flags[FlgComment]) ph = PH_COMMENT;
    if (sec <= SEC_NAME && flags[FlgName]) ph = PH_NAME;
    if (sec == SEC_EXTRA && flags[FlgExtra]) ph = PH_XLEN;
    return ph;
  endfunction

endpackage

### hw/rtl/gsbu_if.sv
`timescale 1ns / 1ps

interface gsbu_in_if import gsbu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             is_final_input;

  modport source(output valid, output data_byte, output is_final_input, input ready);
  modport sink(input valid, input data_byte, input is_final_input, output ready);
endinterface

interface gsbu_out_if import gsbu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   payload_byte;
  logic               payload_valid;
  logic [StatusW-1:0] status;

  modport source(output valid, output payload_byte, output payload_valid, output status,
                 input ready);
  modport sink(input valid, input payload_byte, input payload_valid, input status,
               output ready);
endinterface

### hw/rtl/gsbu_crc.sv
`timescale 1ns / 1ps

module gsbu_crc import gsbu_pkg::*; (
  input  logic [31:0]      crc_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [31:0]      crc_o
);

  // Reflected CRC-32, one byte per call: eight bit steps
  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

### hw/rtl/gsbu_parse.sv
`timescale 1ns / 1ps

module gsbu_parse import gsbu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             is_final_input_i,
  output gsbu_result_t     result_o
);

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [7:0]         flags_q, flags_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [15:0]        rem_q, rem_d;
  logic [31:0]        hold_q, hold_d;
  logic               final_q, final_d;
  logic [31:0]        crc_q, crc_d;
  logic [31:0]        size_q, size_d;
  logic [63:0]        trail_q, trail_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [31:0]        crc_next;
  logic [31:0]        lens_full;
  logic [63:0]        trail_full;
  logic [15:0]        xlen;
  logic               pvalid;

  gsbu_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (data_byte_i),
    .crc_o  (crc_next)
  );

  // Little-endian fields shift in from the top
  assign xlen       = {data_byte_i, hold_q[31:24]};
  assign lens_full  = {data_byte_i, hold_q[31:8]};
  assign trail_full = {data_byte_i, trail_q[63:8]};

  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    hold_d   = hold_q;
    final_d  = final_q;
    crc_d    = crc_q;
    size_d   = size_q;
    trail_d  = trail_q;
    status_d = status_q;
    pvalid   = 1'b0;
    if (status_q == ST_BUSY) begin
      case (phase_q)
        PH_HDR: begin
          if ((cnt_q == 4'd0 && data_byte_i != MAGIC0) ||
              (cnt_q == 4'd1 && data_byte_i != MAGIC1) ||
              (cnt_q == 4'd2 && data_byte_i != METHOD_DEF)) begin
            status_d = ST_BADHDR;
          end else begin
            if (cnt_q == 4'd3) flags_d = data_byte_i;
            cnt_d = cnt_q + 4'd1;
            if (cnt_q == 4'd9) begin
              cnt_d   = '0;
              phase_d = next_section(SEC_EXTRA, flags_q);
            end
          end
        end
        PH_XLEN: begin
          hold_d = lens_full;
          cnt_d  = cnt_q + 4'd1;
          if (cnt_q == 4'd1) begin
            rem_d = xlen;
            cnt_d = '0;
            phase_d = (xlen == 16'd0) ? next_section(SEC_NAME, flags_q) : PH_XDATA;
          end
        end
        PH_XDATA: begin
          rem_d = rem_q - 16'd1;
          if (rem_q == 16'd1) begin
            cnt_d   = '0;
            phase_d = next_section(SEC_NAME, flags_q);
          end
        end
        PH_NAME: begin
          if (data_byte_i == '0) begin
            cnt_d   = '0;
            phase_d = next_section(SEC_COMMENT, flags_q);
          end
        end
        PH_COMMENT: begin
          if (data_byte_i == '0) begin
            cnt_d   = '0;
            phase_d = next_section(SEC_HCRC, flags_q);
          end
        end
        PH_HCRC: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd1) begin
            cnt_d   = '0;
            phase_d = next_section(SEC_NONE, flags_q);
          end
        end
        PH_BLKHDR: begin
          if (data_byte_i[2:1] != 2'b00) begin
            status_d = ST_BADTYPE;
          end else begin
            final_d = data_byte_i[0];
            cnt_d   = '0;
            phase_d = PH_LENS;
          end
        end
        PH_LENS: begin
          hold_d = lens_full;
          cnt_d  = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            if ((lens_full[15:0] ^ lens_full[31:16]) != 16'hffff) begin
              status_d = ST_BADLEN;
            end else begin
              rem_d = lens_full[15:0];
              cnt_d = '0;
              if (lens_full[15:0] == 16'd0) begin
                phase_d = final_q ? PH_TRAILER : PH_BLKHDR;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          pvalid = 1'b1;
          crc_d  = crc_next;
          size_d = size_q + 32'd1;
          rem_d  = rem_q - 16'd1;
          if (rem_q == 16'd1) begin
            cnt_d   = '0;
            phase_d = final_q ? PH_TRAILER : PH_BLKHDR;
          end
        end
        PH_TRAILER: begin
          trail_d = trail_full;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == 4'd7) begin
            status_d = (trail_full[31:0] == ~crc_q && trail_full[63:32] == size_q) ?
                       ST_OK : ST_BADCHECK;
            phase_d  = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (status_d == ST_BUSY && is_final_input_i) status_d = ST_TRUNC;
    end
  end

  assign result_o.payload_byte  = pvalid ? data_byte_i : '0;
  assign result_o.payload_valid = pvalid;
  assign result_o.status        = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      flags_q  <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      hold_q   <= '0;
      final_q  <= 1'b0;
      crc_q    <= '1;
      size_q   <= '0;
      trail_q  <= '0;
      status_q <= ST_BUSY;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      hold_q   <= hold_d;
      final_q  <= final_d;
      crc_q    <= crc_d;
      size_q   <= size_d;
      trail_q  <= trail_d;
      status_q <= status_d;
    end
  end

  // A settled status never moves again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != ST_BUSY |=> $stable(status_q))
    else $error("sticky status changed");

  // Once settled, no more payload leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != ST_BUSY |-> !result_o.payload_valid)
    else $error("payload after final status");

endmodule

### hw/rtl/gzip_stored_block_unwrapper.sv
`timescale 1ns / 1ps

// Unwraps a gzip stream made of stored (uncompressed) deflate blocks.
// Input channel in_i: one raw stream byte per transfer, with is_final_input
// set on the last byte that will ever arrive. Output channel out_o: exactly
// one result per input byte, carrying the payload byte (zero when
// payload_valid is low) and the running status: 0 busy, 1 done ok, 2 bad
// header, 3 unsupported block type, 4 bad LEN/NLEN, 5 CRC or size mismatch,
// 6 truncated. Any nonzero status is sticky; later bytes are consumed and
// answered with the same status and no payload.
// The result for a byte sits in the output register in the cycle after its
// transfer. Throughput: one byte per cycle while the receiver keeps up, set
// by the single parse and CRC step between the input handshake and the
// output register. The output register lets a new byte in whenever it is
// empty or being drained in the same cycle; when the receiver stalls with
// the register full, in_i.ready drops and the held result stays put.
// Reset clears the parser to the first header byte, the CRC to all ones,
// the size to zero and the status to busy, and empties the output register.
module gzip_stored_block_unwrapper import gsbu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsbu_in_if.sink     in_i,
  gsbu_out_if.source  out_o
);

  logic         accept;
  logic         out_valid_q;
  gsbu_result_t result;
  gsbu_result_t result_q;

  // Take a byte whenever the output register is free or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  gsbu_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (accept),
    .data_byte_i      (in_i.data_byte),
    .is_final_input_i (in_i.is_final_input),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload register: load on every input transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = result_q.payload_byte;
  assign out_o.payload_valid = result_q.payload_valid;
  assign out_o.status        = result_q.status;

  // An empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  // A transfer always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("result lost after input transfer");

  // Payload only appears while parsing or at a truncating byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.payload_valid |->
      (result_q.status == ST_BUSY || result_q.status == ST_TRUNC))
    else $error("payload with final status");

endmodule
